/* src/bpfa_pkg.sv */
// bpfa_pkg: shared constants, codes and payload types of the page frame allocator
// no dependencies
`timescale 1ns / 1ps

package bpfa_pkg;

   localparam int MAX_PAGES  = 65536;
   localparam int PAGE_SHIFT = 12;
   localparam int MAX_RUN    = 256;

   localparam int ADDR_W     = 48;
   localparam int CNT_W      = 9;
   localparam int CTR_W      = 17;
   localparam int OP_W       = 3;
   localparam int ST_W       = 3;
   localparam int PG_W       = $clog2(MAX_PAGES);
   localparam int NP_W       = PG_W + 1;
   localparam int PN_W       = ADDR_W - PAGE_SHIFT;
   localparam int WORD_BITS  = 64;
   localparam int WORD_LSB   = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
   localparam int MAP_AW     = PG_W - WORD_LSB;
   localparam int FQ_DEPTH   = 2;
   localparam int FQ_AW      = $clog2(FQ_DEPTH);
   localparam int CSR_IDX_W  = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_RESERVE   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd1;
   localparam logic [OP_W-1:0] OP_REQ_ONE   = 3'd2;
   localparam logic [OP_W-1:0] OP_REQ_RUN   = 3'd3;
   localparam logic [OP_W-1:0] OP_FREE      = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_OK          = 3'd0;
   localparam logic [ST_W-1:0] ST_OUT_RANGE   = 3'd1;
   localparam logic [ST_W-1:0] ST_ALREADY_SET = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_SET     = 3'd3;
   localparam logic [ST_W-1:0] ST_NO_FREE     = 3'd4;
   localparam logic [ST_W-1:0] ST_BELOW_BASE  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_IN_USE = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] address;
      logic [CNT_W-1:0]  count;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ADDR_W-1:0] page_address;
      logic [CTR_W-1:0]  free_pages;
      logic [CTR_W-1:0]  reserved_pages;
      logic [CTR_W-1:0]  locked_pages;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [PG_W-1:0]  page;
      logic             big;
      logic             below;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_type;

endpackage

/* src/bpfa_front.sv */
// bpfa_front: accepts transactions, turns addresses into page indexes, queues commands
// depends on bpfa_pkg
`timescale 1ns / 1ps

module bpfa_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bpfa_pkg::req_type         req_data,
   input  logic [bpfa_pkg::ADDR_W-1:0] base_address,
   input  logic                      take,
   output logic                      q_full,
   output bpfa_pkg::cmdq_type        cmdq
);
   import bpfa_pkg::*;

   cmd_type               fifo_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]      wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [FQ_AW:0]        fill_ff, fill_in;
   logic [ADDR_W:0]       diff;
   logic [PN_W-1:0]       pn;
   cmd_type               cmd;
   logic                  wr, rd;

   always_comb begin
      diff = {1'b0, req_data.address} - {1'b0, base_address};
      if (req_data.op == OP_FREE) begin
         pn = diff[ADDR_W-1:PAGE_SHIFT];
      end else begin
         pn = req_data.address[ADDR_W-1:PAGE_SHIFT];
      end
      cmd.op    = req_data.op;
      cmd.page  = pn[PG_W-1:0];
      cmd.big   = |pn[PN_W-1:PG_W];
      cmd.below = diff[ADDR_W];
      cmd.count = req_data.count;
   end

   assign q_full     = (fill_ff == (FQ_AW+1)'(FQ_DEPTH));
   assign wr         = push && !q_full;
   assign rd         = take && (fill_ff != '0);
   assign cmdq.valid = (fill_ff != '0);
   assign cmdq.cmd   = fifo_ff[rptr_ff];

   always_comb begin
      wptr_in = wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = rd ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + (FQ_AW+1)'(wr) - (FQ_AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         fifo_ff[wptr_ff] <= cmd;
      end
   end

endmodule

/* src/bpfa_back.sv */
// bpfa_back: sequencer that walks the page map memory and carries out commands
// depends on bpfa_pkg
`timescale 1ns / 1ps

module bpfa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bpfa_pkg::cmdq_type          cmdq,
   output logic                        take,
   input  logic [bpfa_pkg::ADDR_W-1:0] base_address,
   input  logic [bpfa_pkg::NP_W-1:0]   num_pages,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        pop,
   output bpfa_pkg::rsp_type           rsp_data
);
   import bpfa_pkg::*;

   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHK   = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_ONE   = 3'd4;
   localparam logic [2:0] S_RUN   = 3'd5;
   localparam logic [2:0] S_FETCH = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_q_ff;
   logic                 mem_we;
   logic [MAP_AW-1:0]    mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   logic [2:0]           state_ff, state_in, ret_ff, ret_in;
   logic [MAP_AW-1:0]    clr_ff, clr_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, run_ff, run_in;
   logic [NP_W-1:0]      pg_ff, pg_in, p0_ff, p0_in, i_ff, i_in;
   logic [NP_W-1:0]      hi_ff, hi_in, start_ff, start_in;
   logic                 pass_ff, pass_in, val_ff, val_in;
   logic [ST_W-1:0]      st_ff, st_in;
   logic [ADDR_W-1:0]    pa_ff, pa_in;
   logic [CTR_W-1:0]     res_ff, res_in, lck_ff, lck_in;
   logic [PG_W-1:0]      sc_ff, sc_in;
   logic [NP_W-1:0]      rc_ff, rc_in;
   logic                 wv_ff, wv_in;
   logic [MAP_AW-1:0]    wa_ff, wa_in;
   logic [WORD_BITS-1:0] wd_ff, wd_in;
   logic                 out_v_ff, out_v_in;
   rsp_type              out_ff, out_in;

   logic                 hit, bit_now, want;
   logic [NP_W-1:0]      cnt_x, pg_inc;
   logic [NP_W:0]        hi_sum;
   logic [CTR_W:0]       res_add, lck_add, lck_one;
   logic [CTR_W-1:0]     cnt_c, res_sub, lck_sub, free_a, free_b;
   logic [ADDR_W-1:0]    pg_addr, p0_addr;
   logic                 load_out;

   assign cnt_x   = NP_W'(cnt_ff);
   assign cnt_c   = CTR_W'(cnt_ff);
   assign pg_inc  = pg_ff + 1'b1;
   assign hit     = wv_ff && (wa_ff == pg_ff[PG_W-1:WORD_LSB]);
   assign bit_now = wd_ff[pg_ff[WORD_LSB-1:0]];
   assign want    = !val_ff;
   assign hi_sum  = {1'b0, start_ff} + (NP_W+1)'(cnt_ff) - 1'b1;
   assign res_add = {1'b0, res_ff} + (CTR_W+1)'(cnt_ff);
   assign lck_add = {1'b0, lck_ff} + (CTR_W+1)'(cnt_ff);
   assign lck_one = {1'b0, lck_ff} + 1'b1;
   assign res_sub = (res_ff > cnt_c) ? res_ff - cnt_c : '0;
   assign lck_sub = (lck_ff > cnt_c) ? lck_ff - cnt_c : '0;
   assign pg_addr = base_address + (ADDR_W'(pg_ff) << PAGE_SHIFT);
   assign p0_addr = base_address + (ADDR_W'(p0_ff) << PAGE_SHIFT);
   assign free_a  = (CTR_W'(num_pages) > res_ff) ? CTR_W'(num_pages) - res_ff : '0;
   assign free_b  = (free_a > lck_ff) ? free_a - lck_ff : '0;

   assign clearing  = (state_ff == S_CLR);
   assign take      = (state_ff == S_IDLE) && cmdq.valid;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign load_out  = (state_ff == S_DONE) && (!out_v_ff || pop);

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      pg_in    = pg_ff;
      p0_in    = p0_ff;
      i_in     = i_ff;
      hi_in    = hi_ff;
      start_in = start_ff;
      pass_in  = pass_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      pa_in    = pa_ff;
      res_in   = res_ff;
      lck_in   = lck_ff;
      sc_in    = sc_ff;
      rc_in    = rc_ff;
      wv_in    = wv_ff;
      wa_in    = wa_ff;
      wd_in    = wd_ff;
      mem_we   = 1'b0;
      mem_wa   = wa_ff;
      mem_wd   = wd_ff;
      out_in   = out_ff;
      out_v_in = out_v_ff && !pop;

      unique case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmdq.valid) begin
               op_in  = cmdq.cmd.op;
               cnt_in = cmdq.cmd.count;
               st_in  = ST_OK;
               pa_in  = '0;
               pg_in  = NP_W'(cmdq.cmd.page);
               p0_in  = NP_W'(cmdq.cmd.page);
               i_in   = '0;
               run_in = '0;
               priority case (cmdq.cmd.op)
                  OP_RESERVE, OP_UNRESERVE, OP_FREE: begin
                     val_in = (cmdq.cmd.op == OP_RESERVE);
                     if (cmdq.cmd.op == OP_FREE && cmdq.cmd.below) begin
                        st_in    = ST_BELOW_BASE;
                        state_in = S_DONE;
                     end else if (cmdq.cmd.big) begin
                        st_in    = (cmdq.cmd.count == '0) ? ST_OK : ST_OUT_RANGE;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_CHK;
                     end
                  end
                  OP_REQ_ONE: begin
                     pg_in    = (NP_W'(sc_ff) < num_pages) ? NP_W'(sc_ff) : '0;
                     state_in = S_ONE;
                  end
                  OP_REQ_RUN: begin
                     val_in   = 1'b1;
                     start_in = (rc_ff < num_pages) ? rc_ff : '0;
                     pg_in    = (rc_ff < num_pages) ? rc_ff : '0;
                     hi_in    = num_pages;
                     pass_in  = 1'b0;
                     if (cmdq.cmd.count > CNT_W'(MAX_RUN) ||
                         (cmdq.cmd.count != '0 && NP_W'(cmdq.cmd.count) > num_pages)) begin
                        st_in    = ST_NO_FREE;
                        state_in = S_DONE;
                     end else if (cmdq.cmd.count == '0) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RUN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CHK: begin
            // every page of the run is checked before anything is written
            if (i_ff == cnt_x) begin
               pg_in    = p0_ff;
               i_in     = '0;
               state_in = S_FILL;
            end else if (pg_ff >= num_pages) begin
               st_in    = ST_OUT_RANGE;
               state_in = S_DONE;
            end else if (!hit) begin
               ret_in   = S_CHK;
               state_in = S_FETCH;
            end else if (bit_now != want) begin
               st_in    = val_ff ? ST_ALREADY_SET : ST_NOT_SET;
               state_in = S_DONE;
            end else begin
               pg_in = pg_inc;
               i_in  = i_ff + 1'b1;
            end
         end
         S_FILL: begin
            if (i_ff == cnt_x) begin
               priority case (op_ff)
                  OP_RESERVE:   res_in = res_add[CTR_W] ? '1 : res_add[CTR_W-1:0];
                  OP_UNRESERVE: res_in = res_sub;
                  OP_REQ_RUN: begin
                     lck_in = lck_add[CTR_W] ? '1 : lck_add[CTR_W-1:0];
                     rc_in  = p0_ff + cnt_x;
                     pa_in  = p0_addr;
                  end
                  default:      lck_in = lck_sub;
               endcase
               state_in = S_DONE;
            end else if (!hit) begin
               ret_in   = S_FILL;
               state_in = S_FETCH;
            end else begin
               wd_in                         = wd_ff;
               wd_in[pg_ff[WORD_LSB-1:0]]    = val_ff;
               mem_we                        = 1'b1;
               mem_wd                        = wd_in;
               pg_in                         = pg_inc;
               i_in                          = i_ff + 1'b1;
            end
         end
         S_ONE: begin
            if (i_ff == num_pages) begin
               st_in    = ST_NO_FREE;
               state_in = S_DONE;
            end else if (!hit) begin
               ret_in   = S_ONE;
               state_in = S_FETCH;
            end else if (!bit_now) begin
               wd_in                      = wd_ff;
               wd_in[pg_ff[WORD_LSB-1:0]] = 1'b1;
               mem_we                     = 1'b1;
               mem_wd                     = wd_in;
               lck_in   = lck_one[CTR_W] ? '1 : lck_one[CTR_W-1:0];
               sc_in    = pg_ff[PG_W-1:0];
               pa_in    = pg_addr;
               state_in = S_DONE;
            end else begin
               i_in  = i_ff + 1'b1;
               pg_in = (pg_inc == num_pages) ? '0 : pg_inc;
            end
         end
         S_RUN: begin
            if (pg_ff >= hi_ff) begin
               if (!pass_ff) begin
                  // second pass wraps to page zero
                  pass_in = 1'b1;
                  pg_in   = '0;
                  run_in  = '0;
                  hi_in   = (hi_sum > (NP_W+1)'(num_pages)) ? num_pages : hi_sum[NP_W-1:0];
               end else begin
                  st_in    = ST_NO_FREE;
                  state_in = S_DONE;
               end
            end else if (!hit) begin
               ret_in   = S_RUN;
               state_in = S_FETCH;
            end else if (bit_now) begin
               run_in = '0;
               pg_in  = pg_inc;
            end else if (run_ff + 1'b1 >= cnt_ff) begin
               p0_in    = pg_inc - cnt_x;
               pg_in    = pg_inc - cnt_x;
               i_in     = '0;
               state_in = S_FILL;
            end else begin
               run_in = run_ff + 1'b1;
               pg_in  = pg_inc;
            end
         end
         S_FETCH: begin
            wv_in    = 1'b1;
            wa_in    = pg_ff[PG_W-1:WORD_LSB];
            wd_in    = rd_q_ff;
            state_in = ret_ff;
         end
         S_DONE: begin
            if (load_out) begin
               out_in.status         = st_ff;
               out_in.page_address   = pa_ff;
               out_in.free_pages     = free_b;
               out_in.reserved_pages = res_ff;
               out_in.locked_pages   = lck_ff;
               out_v_in              = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         res_ff   <= '0;
         lck_ff   <= '0;
         sc_ff    <= '0;
         rc_ff    <= '0;
         wv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         res_ff   <= res_in;
         lck_ff   <= lck_in;
         sc_ff    <= sc_in;
         rc_ff    <= rc_in;
         wv_ff    <= wv_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      run_ff   <= run_in;
      pg_ff    <= pg_in;
      p0_ff    <= p0_in;
      i_ff     <= i_in;
      hi_ff    <= hi_in;
      start_ff <= start_in;
      pass_ff  <= pass_in;
      val_ff   <= val_in;
      st_ff    <= st_in;
      pa_ff    <= pa_in;
      wa_ff    <= wa_in;
      wd_ff    <= wd_in;
      out_ff   <= out_in;
   end

   // page map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[pg_ff[PG_W-1:WORD_LSB]];
   end

endmodule

/* src/bitmap_page_frame_allocator.sv */
// bitmap_page_frame_allocator: top level of the next-fit page frame allocator
// depends on bpfa_pkg, bpfa_front, bpfa_back
`timescale 1ns / 1ps

//  channel   ports                           direction  transaction when
//  request   push, full, req_data            in         push & !full
//  response  empty, pop, rsp_data            out        pop & !empty
//  csr       csr_valid, csr_ready, csr_index,
//            csr_data                        in         csr_valid & csr_ready
//
//  after reset the page map is wiped one 64-page word a cycle, 1024 words
//  in all: full stays high during the wipe; csr writes are taken throughout
//  the map sequencer takes one item at a time, visiting its pages in turn
//  and loading a map word whenever a page lies outside the word it holds
//  reserve, unreserve and free check every page before writing; requests walk
//  from their cursor, up to the managed page count (twice for runs)
//  a two-entry command queue lets requests land while a response waits

module bitmap_page_frame_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  bpfa_pkg::req_type              req_data,
   output logic                           empty,
   input  logic                           pop,
   output bpfa_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpfa_pkg::ADDR_W-1:0]    csr_data
);
   import bpfa_pkg::*;

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CTR_W-1:0]  piu_ff, piu_in;
   logic [NP_W-1:0]   num_pages;
   logic              q_full, take, clearing, rsp_valid;
   cmdq_type          cmdq;

   // csr writes are always accepted and land in the next cycle
   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      piu_in  = piu_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_in = csr_data;
            CSR_PAGES_IN_USE: piu_in  = csr_data[CTR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         piu_ff  <= '0;
      end else begin
         base_ff <= base_in;
         piu_ff  <= piu_in;
      end
   end

   // effective page count, clipped to the map size
   assign num_pages = (piu_ff > CTR_W'(MAX_PAGES)) ? NP_W'(MAX_PAGES) : NP_W'(piu_ff);

   // no requests while the map wipe runs
   assign full  = q_full || clearing;
   assign empty = !rsp_valid;

   bpfa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push && !clearing),
      .req_data     (req_data),
      .base_address (base_ff),
      .take         (take),
      .q_full       (q_full),
      .cmdq         (cmdq)
   );

   bpfa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmdq         (cmdq),
      .take         (take),
      .base_address (base_ff),
      .num_pages    (num_pages),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .pop          (pop),
      .rsp_data     (rsp_data)
   );

endmodule

/* src/bpfa_checker.sv */
// bpfa_checker: port-level assertions for the page frame allocator, bound to the top
// depends on bpfa_pkg and bitmap_page_frame_allocator
`timescale 1ns / 1ps

module bpfa_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input bpfa_pkg::rsp_type rsp_data
);
   import bpfa_pkg::*;

   // map wipe blocks requests right after reset
   a_wipe_after_reset: assert property (@(posedge clock) reset |=> full)
      else $error("full not raised during map wipe");

   // no response is waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("response present after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("response changed while waiting");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.status <= ST_BELOW_BASE))
      else $error("bad status code");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.free_pages <= CTR_W'(MAX_PAGES)))
      else $error("free count above map size");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
   .clock     (clock),
   .reset     (reset),
   .full      (full),
   .empty     (empty),
   .pop       (pop),
   .rsp_data  (rsp_data)
);
